/* rtl/bbhc_pkg.sv */
// shared types and constants for the bang-bang heading command pipeline
// no dependencies
package bbhc_pkg;

  localparam int CW       = 38;   // cordic x/y datapath width
  localparam int ZW       = 20;   // angle accumulator width, 2^-16 rad
  localparam int SQW      = 32;   // square root radicand width
  localparam int SQ_STEPS = 16;   // result bits of the square root
  localparam int ATAN_LEN = 24;

  localparam int DEF_ROBOT_COUNT      = 16;
  localparam int DEF_ANGLE_ITERATIONS = 16;

  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;
  localparam logic signed [16:0]   HALF_PI_Q13 = 17'sd12868;
  localparam logic [14:0]          TURN_RATE_RESET = 15'd6554;

  localparam logic signed [ZW-1:0] ATAN_Q16 [0:ATAN_LEN-1] = '{
    20'sd51472, 20'sd30386, 20'sd16055, 20'sd8150, 20'sd4091, 20'sd2047,
    20'sd1024,  20'sd512,   20'sd256,   20'sd128,  20'sd64,   20'sd32,
    20'sd16,    20'sd8,     20'sd4,     20'sd2,    20'sd1,    20'sd0,
    20'sd0,     20'sd0,     20'sd0,     20'sd0,    20'sd0,    20'sd0
  };

  typedef struct packed {
    logic                  valid;
    logic [3:0]            idx;
    logic                  zero_vel;
    logic                  yaw_zero;
    logic                  vert;
    logic                  vy_pos;
    logic signed [CW-1:0]  yx;
    logic signed [CW-1:0]  yy;
    logic signed [ZW-1:0]  yz;
    logic signed [CW-1:0]  hx;
    logic signed [CW-1:0]  hy;
    logic signed [ZW-1:0]  hz;
    logic [SQW-1:0]        sq_n;
    logic [SQW-1:0]        sq_r;
  } stage_t;

endpackage

/* rtl/bbhc_stage.sv */
// one pipeline step: a vectoring cordic iteration for yaw and heading while STEP < ITERS
// plus one digit of the speed square root while STEP < SQ_STEPS; uses bbhc_pkg
module bbhc_stage #(
  parameter int STEP  = 0,
  parameter int ITERS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  bbhc_pkg::stage_t d,
  output bbhc_pkg::stage_t q
);
  import bbhc_pkg::*;

  localparam int BS = (STEP < SQ_STEPS) ? (30 - 2 * STEP) : 0;
  localparam logic [SQW-1:0] SQ_BIT = SQW'(1) << BS;

  stage_t s;
  logic [SQW-1:0] trial;

  always_comb begin
    s = d;
    trial = d.sq_r + SQ_BIT;
    if (STEP < ITERS) begin
      if (!d.yy[CW-1]) begin
        s.yx = d.yx + (d.yy >>> STEP);
        s.yy = d.yy - (d.yx >>> STEP);
        s.yz = d.yz + ATAN_Q16[STEP];
      end else begin
        s.yx = d.yx - (d.yy >>> STEP);
        s.yy = d.yy + (d.yx >>> STEP);
        s.yz = d.yz - ATAN_Q16[STEP];
      end
      if (!d.hy[CW-1]) begin
        s.hx = d.hx + (d.hy >>> STEP);
        s.hy = d.hy - (d.hx >>> STEP);
        s.hz = d.hz + ATAN_Q16[STEP];
      end else begin
        s.hx = d.hx - (d.hy >>> STEP);
        s.hy = d.hy + (d.hx >>> STEP);
        s.hz = d.hz - ATAN_Q16[STEP];
      end
    end
    if (STEP < SQ_STEPS) begin
      if (d.sq_n >= trial) begin
        s.sq_n = d.sq_n - trial;
        s.sq_r = (d.sq_r >> 1) + SQ_BIT;
      end else begin
        s.sq_r = d.sq_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q <= s;
    end
  end

endmodule

/* rtl/bang_bang_heading_command.sv */
// top level: speed magnitude and bang-bang turn command per robot
// uses bbhc_pkg and bbhc_stage
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata: velocity, quaternion; tuser: robot index
//  m_axis    out  tvalid/tready          tdata: speed, turn; tuser: robot index
//  cfg       in   cfg_valid/cfg_ready    cfg_data: turn_rate
//
// one item per cycle while the output register is empty or taken; items pass through the input,
// product and setup registers, the chain of cordic/square root stages and the output register.
// the whole pipeline advances when the output register is empty or taken;
// a stall freezes every stage. reset clears all valid bits and sets turn_rate to 0.4.
// items with robot index at or above ROBOT_COUNT produce no result.
module bang_bang_heading_command #(
  parameter int ROBOT_COUNT      = bbhc_pkg::DEF_ROBOT_COUNT,
  parameter int ANGLE_ITERATIONS = bbhc_pkg::DEF_ANGLE_ITERATIONS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // vel_x, vel_y, quat_x, quat_y, quat_z, quat_w (16 bits each)
  input  logic [95:0] s_axis_tdata,
  // robot_index
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // forward_speed, turn_command (16 bits each)
  output logic [31:0] m_axis_tdata,
  // robot_index_out
  output logic [3:0]  m_axis_tuser,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);
  import bbhc_pkg::*;

  localparam int NSTG = (ANGLE_ITERATIONS > SQ_STEPS) ? ANGLE_ITERATIONS : SQ_STEPS;

  logic adv;
  logic [14:0] turn_rate;

  assign adv = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) turn_rate <= TURN_RATE_RESET;
    else if (cfg_valid) turn_rate <= cfg_data;
  end

  // input register
  logic a_valid;
  logic [3:0] a_idx;
  logic signed [15:0] a_vx, a_vy, a_qx, a_qy, a_qz, a_qw;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s_axis_tvalid && (32'(s_axis_tuser) < ROBOT_COUNT);
      a_idx <= s_axis_tuser;
      a_vx <= s_axis_tdata[15:0];
      a_vy <= s_axis_tdata[31:16];
      a_qx <= s_axis_tdata[47:32];
      a_qy <= s_axis_tdata[63:48];
      a_qz <= s_axis_tdata[79:64];
      a_qw <= s_axis_tdata[95:80];
    end
  end

  // product register
  logic b_valid;
  logic [3:0] b_idx;
  logic signed [15:0] b_vx, b_vy;
  logic signed [31:0] b_wz, b_xy, b_zz, b_yy, b_vxx, b_vyy;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
      b_idx <= a_idx;
      b_vx <= a_vx;
      b_vy <= a_vy;
      b_wz <= a_qw * a_qz;
      b_xy <= a_qx * a_qy;
      b_zz <= a_qz * a_qz;
      b_yy <= a_qy * a_qy;
      b_vxx <= a_vx * a_vx;
      b_vyy <= a_vy * a_vy;
    end
  end

  // setup: yaw vector with half-plane rotation, heading vector, radicand
  stage_t stg [0:NSTG];
  stage_t c_next;
  logic signed [33:0] num, den;
  logic signed [CW-1:0] vxs, vys;

  always_comb begin
    num = (34'(b_wz) + 34'(b_xy)) <<< 1;
    den = (34'sd1 <<< 28) - ((34'(b_zz) + 34'(b_yy)) <<< 1);
    vxs = CW'(b_vx) <<< 16;
    vys = CW'(b_vy) <<< 16;
    c_next = '0;
    c_next.valid = b_valid;
    c_next.idx = b_idx;
    c_next.zero_vel = (b_vx == 16'sd0) && (b_vy == 16'sd0);
    c_next.yaw_zero = (num == 34'sd0) && (den == 34'sd0);
    c_next.vert = (b_vx == 16'sd0);
    c_next.vy_pos = (b_vy > 16'sd0);
    if (den[33]) begin
      if (!num[33]) begin
        c_next.yx = CW'(num);
        c_next.yy = -CW'(den);
        c_next.yz = HALF_PI_Q16;
      end else begin
        c_next.yx = -CW'(num);
        c_next.yy = CW'(den);
        c_next.yz = -HALF_PI_Q16;
      end
    end else begin
      c_next.yx = CW'(den);
      c_next.yy = CW'(num);
      c_next.yz = '0;
    end
    if (b_vx[15]) begin
      c_next.hx = -vxs;
      c_next.hy = -vys;
    end else begin
      c_next.hx = vxs;
      c_next.hy = vys;
    end
    c_next.sq_n = SQW'(b_vxx) + SQW'(b_vyy);
    c_next.sq_r = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stg[0].valid <= 1'b0;
    end else if (adv) begin
      stg[0] <= c_next;
    end
  end

  for (genvar g = 0; g < NSTG; g++) begin : g_stage
    bbhc_stage #(.STEP(g), .ITERS(ANGLE_ITERATIONS)) u_stage (
      .clk(clk), .rst(rst), .en(adv), .d(stg[g]), .q(stg[g+1])
    );
  end

  // rounding, compare and output register
  stage_t f;
  logic signed [ZW-1:0] yaw_r, head_r;
  logic signed [16:0] yaw, head;
  logic [15:0] speed_next, turn_next;

  always_comb begin
    f = stg[NSTG];
    yaw_r = (f.yz + ZW'(4)) >>> 3;
    head_r = (f.hz + ZW'(4)) >>> 3;
    yaw = f.yaw_zero ? 17'sd0 : yaw_r[16:0];
    head = f.vert ? (f.vy_pos ? HALF_PI_Q13 : -HALF_PI_Q13) : head_r[16:0];
    speed_next = (f.sq_r > SQW'(16'hFFFF)) ? 16'hFFFF : f.sq_r[15:0];
    if (yaw > head) turn_next = 16'd0 - {1'b0, turn_rate};
    else if (yaw < head) turn_next = {1'b0, turn_rate};
    else turn_next = 16'd0;
    if (f.zero_vel) begin
      speed_next = 16'd0;
      turn_next = 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= f.valid;
      m_axis_tuser <= f.idx;
      m_axis_tdata <= {turn_next, speed_next};
    end
  end

  a_turn_zero_speed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[31:16] != 16'd0) |-> (m_axis_tdata[15:0] != 16'd0))
    else $error("turn command without forward speed");

  a_turn_levels: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[31:16] == 16'd0) ||
                      (m_axis_tdata[31:16] == {1'b0, turn_rate}) ||
                      (m_axis_tdata[31:16] == 16'd0 - {1'b0, turn_rate}))
    else $error("turn command not a turn_rate level");

  a_speed_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[15:0] <= 16'd46341))
    else $error("speed above largest vector magnitude");

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps
// self-checking testbench for bang_bang_heading_command: speed magnitude and bang-bang turn
// depends on rtl/bbhc_pkg.sv and rtl/bang_bang_heading_command.sv
module testbench;
  import bbhc_pkg::*;

  localparam int LAT = 20;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int ROBOTS = 16;
  localparam int ITERS = 16;

  typedef struct {
    logic [3:0] robot;
    logic signed [15:0] vx, vy, qx, qy, qz, qw;
  } cmd_t;

  typedef struct {
    logic [3:0] robot;
    logic [15:0] speed;
    logic signed [15:0] turn;
  } reply_t;

  logic clk = 0;
  logic rst = 1;
  logic s_axis_tvalid = 0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic [3:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [14:0] cfg_data = '0;

  reply_t expected_replies[$];
  logic [14:0] rate_model;
  int errors = 0;
  int cycles = 0;
  int replies_seen = 0;
  int items_sent = 0;

  always #2 clk = ~clk;

  bang_bang_heading_command i_dut (.*);

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint angle_vec(longint y, longint x);
    longint z, t, dx, dy;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = HALF_PI_Q16;
      end else begin
        x = -y; y = t; z = -HALF_PI_Q16;
      end
    end
    for (int i = 0; i < ITERS; i++) begin
      dx = floor_shift(y, i);
      dy = floor_shift(x, i);
      if (y >= 0) begin
        x += dx; y -= dy; z += ATAN_Q16[i];
      end else begin
        x -= dx; y += dy; z -= ATAN_Q16[i];
      end
    end
    return floor_shift(z + 4, 3);
  endfunction

  function automatic longint int_sqrt(longint n);
    longint r, b;
    r = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else r >>= 1;
      b >>= 2;
    end
    return r;
  endfunction

  function automatic reply_t predict_command(cmd_t c);
    reply_t r;
    longint vx, vy, qx, qy, qz, qw, num, den, yaw, head, sp;
    vx = c.vx; vy = c.vy; qx = c.qx; qy = c.qy; qz = c.qz; qw = c.qw;
    r.robot = c.robot;
    r.speed = 0;
    r.turn = 0;
    if (vx != 0 || vy != 0) begin
      sp = int_sqrt(vx * vx + vy * vy);
      r.speed = (sp > 65535) ? 16'hffff : sp[15:0];
      num = 2 * (qw * qz + qx * qy);
      den = (64'sd1 <<< 28) - 2 * (qz * qz + qy * qy);
      yaw = (num == 0 && den == 0) ? 0 : angle_vec(num, den);
      if (vx == 0) head = (vy > 0) ? HALF_PI_Q13 : -HALF_PI_Q13;
      else if (vx > 0) head = angle_vec(vy * 65536, vx * 65536);
      else head = angle_vec(-vy * 65536, -vx * 65536);
      if (yaw > head) r.turn = -$signed({1'b0, rate_model});
      else if (yaw < head) r.turn = $signed({1'b0, rate_model});
    end
    return r;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("** bang_bang_heading_command: FAILED **");
      $finish;
    end
  end

  // output side: random stall, check each transfer
  initial begin
    int gap;
    reply_t e;
    @(posedge clk iff !rst);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 4) == 0) gap = 0;
      repeat (gap) begin
        m_axis_tready <= 0;
        @(posedge clk);
      end
      m_axis_tready <= 1;
      @(posedge clk iff m_axis_tvalid);
      replies_seen++;
      if (expected_replies.size() == 0) begin
        $error("unexpected result robot=%0d", m_axis_tuser);
        errors++;
      end else begin
        e = expected_replies.pop_front();
        if (m_axis_tuser !== e.robot) begin
          $error("robot_index_out exp %0d got %0d", e.robot, m_axis_tuser); errors++;
        end
        if (m_axis_tdata[15:0] !== e.speed) begin
          $error("forward_speed exp %0d got %0d", e.speed, m_axis_tdata[15:0]); errors++;
        end
        if (m_axis_tdata[31:16] !== e.turn) begin
          $error("turn_command exp %0d got %0d", e.turn, $signed(m_axis_tdata[31:16]));
          errors++;
        end
      end
    end
  end

  task automatic write_rate(logic [14:0] v);
    cfg_valid <= 1;
    cfg_data <= v;
    @(posedge clk iff cfg_ready);
    cfg_valid <= 0;
    rate_model = v;
  endtask

  task automatic drain();
    wait (expected_replies.size() == 0);
    repeat (LAT + 4) @(posedge clk);
  endtask

  // sends one command; a check value overrides the predictor when given
  task automatic send_command(cmd_t c, bit has_fixed = 0, reply_t fixed = '{0, 0, 0});
    int gap;
    reply_t exp_r;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if ($urandom_range(0, 4) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tuser <= c.robot;
    s_axis_tdata <= {c.qw, c.qz, c.qy, c.qx, c.vy, c.vx};
    @(posedge clk iff s_axis_tready);
    items_sent++;
    if (c.robot < ROBOTS) begin
      exp_r = has_fixed ? fixed : predict_command(c);
      expected_replies.insert(expected_replies.size(), exp_r);
    end
  endtask

  function automatic logic signed [15:0] rand_quat();
    case ($urandom_range(0, 5))
      0: return 16'sd16384;
      1: return -16'sd16384;
      2: return 16'sh8000;
      3: return 16'($urandom);
      default: return $signed(16'($urandom_range(0, 32768))) - 16'sd16384;
    endcase
  endfunction

  function automatic cmd_t rand_command();
    cmd_t c;
    c.robot = 4'($urandom);
    c.vx = 16'($urandom);
    c.vy = 16'($urandom);
    case ($urandom_range(0, 7))
      0: c.vx = 0;
      1: c.vy = 0;
      2: begin c.vx = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000; end
      3: begin c.vx = 0; c.vy = 0; end
      4: begin c.vx = $signed(16'($urandom_range(0, 8))) - 16'sd4; end
      default: ;
    endcase
    c.qx = rand_quat(); c.qy = rand_quat(); c.qz = rand_quat(); c.qw = rand_quat();
    if ($urandom_range(0, 9) == 0) begin
      c.qx = 0; c.qy = 0; c.qz = 0; c.qw = 0;
    end
    return c;
  endfunction

  typedef struct {
    cmd_t cmd;
    bit fixed;
    reply_t res;
  } row_t;

  row_t directed_rows[] = '{
    '{'{0, 0, 0, 0, 0, 0, 16384}, 1, '{0, 0, 0}},
    '{'{15, 0, 0, 100, -200, 300, 16384}, 1, '{15, 0, 0}},
    '{'{3, 16'sh7fff, 16'sh7fff, 0, 0, 0, 16384}, 0, '{0, 0, 0}},
    '{'{4, 16'sh8000, 16'sh8000, 0, 0, 0, 16384}, 0, '{0, 0, 0}},
    '{'{5, 16'sh8000, 0, 0, 0, 0, 16384}, 1, '{5, 16'd32768, 0}},
    '{'{6, 4096, 0, 0, 0, 0, 16384}, 1, '{6, 16'd4096, 0}},
    '{'{7, 0, 4096, 0, 0, 0, 16384}, 1, '{7, 16'd4096, 16'sd6554}},
    '{'{8, 0, -4096, 0, 0, 0, 16384}, 1, '{8, 16'd4096, -16'sd6554}},
    '{'{9, 0, 1, 0, 0, 16384, 0}, 0, '{0, 0, 0}},
    '{'{10, -4096, 1000, 0, 0, 16384, 0}, 0, '{0, 0, 0}},
    '{'{11, 3000, -3000, 0, 16384, 0, 0}, 0, '{0, 0, 0}},
    '{'{12, 1, 1, 0, 0, 0, 0}, 0, '{0, 0, 0}},
    '{'{13, -5, 7, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}, 0, '{0, 0, 0}},
    '{'{14, 200, 200, -16384, 16384, -16384, 16384}, 0, '{0, 0, 0}},
    '{'{1, 16'sh7fff, 16'sh8000, 16384, 0, 0, 0}, 0, '{0, 0, 0}},
    '{'{2, -1, -1, 0, 0, -11585, 11585}, 0, '{0, 0, 0}}
  };

  initial begin
    cmd_t c;
    logic [14:0] rates[] = '{15'd0, 15'd32767, 15'd1, 15'd16384};
    rate_model = TURN_RATE_RESET;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed_rows[i])
      send_command(directed_rows[i].cmd, directed_rows[i].fixed, directed_rows[i].res);
    for (int phase = 0; phase < 5; phase++) begin
      for (int n = 0; n < 290; n++) begin
        c = rand_command();
        send_command(c);
      end
      s_axis_tvalid <= 0;
      drain();
      if (phase < 4) begin
        write_rate(phase == 3 ? 15'($urandom) : rates[phase]);
      end
    end
    $display("sent %0d commands over five turn rates (reset, 0, max, 1, random), %0d results",
             items_sent, replies_seen);
    if (errors == 0) begin
      $display("** bang_bang_heading_command: PASSED **");
    end else begin
      $display("** bang_bang_heading_command: FAILED **");
    end
    $finish;
  end

endmodule

/* bang_bang_heading_command.f */
rtl/bbhc_pkg.sv
rtl/bbhc_stage.sv
rtl/bang_bang_heading_command.sv
verif/testbench.sv
